// File: hdl/hlg_pkg.sv
// ----------------------------------------------------------------------------
// hlg_pkg
// Shared types and constants for the streaming Huber loss and gradient block.
// ----------------------------------------------------------------------------
package hlg_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int CNT_W        = 13;
    localparam int SUM_W        = 48;
    localparam int ITER_W       = 6;
    localparam int ADDR_W       = 4;

    localparam logic [1:0] REG_HUBER_DELTA   = 2'd0;
    localparam logic [1:0] REG_ELEMENT_COUNT = 2'd1;
    localparam logic [1:0] REG_BACKWARD_MODE = 2'd2;
    localparam logic [1:0] REG_UPSTREAM_GRAD = 2'd3;

    localparam logic RESULT_LOSS = 1'b0;
    localparam logic RESULT_GRAD = 1'b1;

    typedef struct packed {
        logic signed [15:0] pred_value;
        logic signed [15:0] target_value;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [31:0]        loss_mean;
        logic signed [31:0] grad_increment;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        huber_delta;
        logic [CNT_W-1:0]   element_count;
        logic               backward_mode;
        logic signed [15:0] upstream_grad;
    } t_cfg;

endpackage

// File: hdl/hlg_cfg.sv
// ----------------------------------------------------------------------------
// hlg_cfg
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module hlg_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hlg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output hlg_pkg::t_cfg             o_cfg
);
    import hlg_pkg::*;

    t_cfg        r_cfg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.huber_delta   <= 16'd256;
            r_cfg.element_count <= CNT_W'(MAX_ELEMENTS);
            r_cfg.backward_mode <= 1'b0;
            r_cfg.upstream_grad <= 16'sd256;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_HUBER_DELTA:   r_cfg.huber_delta   <= pwdata[15:0];
                REG_ELEMENT_COUNT: r_cfg.element_count <= pwdata[CNT_W-1:0];
                REG_BACKWARD_MODE: r_cfg.backward_mode <= pwdata[0];
                REG_UPSTREAM_GRAD: r_cfg.upstream_grad <= pwdata[15:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_HUBER_DELTA:   prdata = {16'd0, r_cfg.huber_delta};
            REG_ELEMENT_COUNT: prdata = {{(32-CNT_W){1'b0}}, r_cfg.element_count};
            REG_BACKWARD_MODE: prdata = {31'd0, r_cfg.backward_mode};
            REG_UPSTREAM_GRAD: prdata = {16'd0, r_cfg.upstream_grad};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// File: hdl/hlg_div.sv
// ----------------------------------------------------------------------------
// hlg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hlg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hlg_pkg::SUM_W-1:0]  i_dividend,
    input  logic [hlg_pkg::ITER_W-1:0] i_iters,
    input  logic [hlg_pkg::CNT_W-1:0]  i_divisor,
    output logic                      o_busy,
    output logic [hlg_pkg::SUM_W-1:0]  o_quotient
);
    import hlg_pkg::*;

    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign ge         = trial >= {1'b0, i_divisor};
    assign diff       = trial - {1'b0, i_divisor};
    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_cnt <= r_cnt - ITER_W'(1);
            if (r_cnt == ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

endmodule

// File: hdl/huber_loss_with_gradient.sv
// A forward item that does not close a tensor passes S_MUL and S_ACC and gives no result.
// A closing item gives its mean, and a backward item its gradient, through S_MUL, S_ACC,
// S_DIV and S_OUT into the output register; the next transaction is taken in S_IDLE.
// Items are taken one at a time, through the 48- or 32-step shared divider, and a result
// waits in the sequencer while the output register is held.
// Reset (synchronous, active low) clears the sum, the count, the sequencer and the output
// register, and loads the register defaults.
// ----------------------------------------------------------------------------
// huber_loss_with_gradient
// Streaming Huber loss and gradient with a shared multiplier and divider.
// ----------------------------------------------------------------------------
module huber_loss_with_gradient (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  hlg_pkg::t_in_item         i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output hlg_pkg::t_out_item        o_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hlg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import hlg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_DIV, S_OUT} t_state;

    t_state             r_state;
    t_cfg               cfg;
    logic signed [16:0] r_d;
    logic [32:0]        r_prod;
    logic               r_neg;
    logic               r_kind;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_seen;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CNT_W-1:0]   n_eff;
    logic [16:0]        d_abs17;
    logic [15:0]        d_abs;
    logic signed [16:0] ug_ext;
    logic [16:0]        ug_abs;
    logic               quad;
    logic [15:0]        op_a;
    logic [16:0]        op_b;
    logic [32:0]        prod;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   sum_sat;
    logic               last_item;
    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [ITER_W-1:0]  div_iters;
    logic               div_busy;
    logic [SUM_W-1:0]   quo;
    logic [31:0]        grad_mag;
    t_out_item          n_out;
    logic               out_free;

    hlg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hlg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_iters    (div_iters),
        .i_divisor  (n_eff),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        priority if (cfg.element_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (cfg.element_count > CNT_W'(MAX_ELEMENTS)) begin
            n_eff = CNT_W'(MAX_ELEMENTS);
        end else begin
            n_eff = cfg.element_count;
        end
    end

    // Shared multiplier: the Huber term in forward mode, |clip(d)| * |grad| otherwise.
    always_comb begin
        d_abs17 = r_d[16] ? 17'(-r_d) : 17'(r_d);
        d_abs   = d_abs17[15:0];
        ug_ext  = {cfg.upstream_grad[15], cfg.upstream_grad};
        ug_abs  = ug_ext[16] ? 17'(-ug_ext) : 17'(ug_ext);
        quad    = d_abs <= cfg.huber_delta;
        if (cfg.backward_mode) begin
            op_a = quad ? d_abs : cfg.huber_delta;
            op_b = ug_abs;
        end else begin
            op_a = quad ? d_abs : cfg.huber_delta;
            op_b = quad ? {1'b0, d_abs} : ({d_abs, 1'b0} - {1'b0, cfg.huber_delta});
        end
        prod = 33'(op_a) * 33'(op_b);
    end

    always_comb begin
        sum_ext   = {1'b0, r_sum} + (SUM_W+1)'(r_prod[32:1]);
        sum_sat   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        last_item = ({1'b0, r_seen} + (CNT_W+1)'(1)) >= {1'b0, n_eff};
        div_start = (r_state == S_ACC) && (cfg.backward_mode || last_item);
        if (cfg.backward_mode) begin
            div_dividend = {r_prod[31:0], 16'd0};
            div_iters    = ITER_W'(32);
        end else begin
            div_dividend = sum_sat;
            div_iters    = ITER_W'(SUM_W);
        end
    end

    always_comb begin
        grad_mag = quo[31:0];
        n_out    = '0;
        if (r_kind == RESULT_GRAD) begin
            n_out.result_kind    = RESULT_GRAD;
            n_out.grad_increment = r_neg ? -grad_mag : grad_mag;
        end else begin
            n_out.result_kind = RESULT_LOSS;
            n_out.loss_mean   = (quo[SUM_W-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
        end
        out_free = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (cfg.backward_mode) begin
                        r_kind  <= RESULT_GRAD;
                        r_state <= S_DIV;
                    end else if (last_item) begin
                        r_kind  <= RESULT_LOSS;
                        r_sum   <= '0;
                        r_seen  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_sum   <= sum_sat;
                        r_seen  <= r_seen + CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (!div_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_d <= {i_data.pred_value[15], i_data.pred_value}
                 - {i_data.target_value[15], i_data.target_value};
        end
        if (r_state == S_MUL) begin
            r_prod <= prod;
            r_neg  <= r_d[16] ^ cfg.upstream_grad[15];
        end
    end

endmodule
